// ----- src/smej_pkg.sv -----
// Shared types and constants for the sorted merge equi-join.
package smej_pkg;

  localparam int COL_W      = 64;
  localparam int IN_COLS    = 4;
  localparam int OUT_COLS   = 8;
  localparam int WIDTH_W    = 4;
  localparam int POS_W      = 2;
  localparam int MASK_W     = 4;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 4;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;

  localparam int S_DATA_W = ((IN_COLS * COL_W + 7) / 8) * 8;
  localparam int M_BITS   = OUT_COLS * COL_W + WIDTH_W;
  localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;
  localparam int M_PAD_W  = M_DATA_W - M_BITS;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_PROBE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_JOINED      = 2'd0,
    ST_FULL        = 2'd1,
    ST_LEFT_ORDER  = 2'd2,
    ST_PROBE_ORDER = 2'd3
  } status_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LEFT_KEY_POS    = 2'd0,
    CFG_RIGHT_KEY_POS   = 2'd1,
    CFG_LEFT_COPY_MASK  = 2'd2,
    CFG_RIGHT_COPY_MASK = 2'd3
  } cfg_idx_t;

  typedef logic [IN_COLS-1:0][COL_W-1:0]  in_row_t;
  typedef logic [OUT_COLS-1:0][COL_W-1:0] out_row_t;

endpackage

// ----- src/sorted_merge_equi_join.sv -----
// Sorted merge equi-join: left row store, forward scan pointer and result packing.
// Clear and load complete in the idle state; a load error result is registered for output.
// Probe: each scanned row passes S_READ (registered store read), then S_CHECK (compare);
//   a match is staged and sent at the next match or from S_FINISH, which ends the probe.
// The block takes one request at a time; it waits while its output register is full.
// Reset clears pointers, counts and flags and sets config to key column 0, all masks set;
//   store contents are undefined until loaded and need no clearing pass.
module sorted_merge_equi_join
  import smej_pkg::*;
#(
  parameter int LEFT_DEPTH = 64,
  parameter int MAX_ARITY  = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_DATA_W-1:0]   s_tdata,   // value_0, value_1, value_2, value_3
  input  logic [CMD_W-1:0]      s_tuser,   // command
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_DATA_W-1:0]   m_tdata,   // out_value_0 .. out_value_7, out_width, zero pad
  output logic [STATUS_W-1:0]   m_tuser,   // status
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (LEFT_DEPTH > 1) ? $clog2(LEFT_DEPTH) : 1;
  localparam int CW = $clog2(LEFT_DEPTH + 1);
  localparam int KW = (MAX_ARITY > 1) ? $clog2(MAX_ARITY) : 1;

  typedef logic [MAX_ARITY-1:0][COL_W-1:0] row_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_FINISH
  } state_t;

  function automatic logic [KW-1:0] clamp_col(input logic [POS_W-1:0] pos);
    logic [POS_W-1:0] c;
    c = (int'(pos) >= MAX_ARITY) ? POS_W'(MAX_ARITY - 1) : pos;
    return c[KW-1:0];
  endfunction

  state_t            state;
  logic [POS_W-1:0]  left_key_pos;
  logic [POS_W-1:0]  right_key_pos;
  logic [MASK_W-1:0] left_copy_mask;
  logic [MASK_W-1:0] right_copy_mask;

  row_t              mem [LEFT_DEPTH];
  row_t              rd_row;
  row_t              last_row;
  row_t              probe_row;
  logic [COL_W-1:0]  probe_key;
  logic [COL_W-1:0]  last_probe_key;
  logic              probe_seen;
  logic [CW-1:0]     left_count;
  logic [CW-1:0]     group_start;
  logic [CW-1:0]     scan;

  logic              staged;
  out_row_t          staged_vals;
  logic [WIDTH_W-1:0] staged_width;

  out_row_t          out_vals;
  logic [WIDTH_W-1:0] out_width;
  status_t           out_status;

  in_row_t           in_row;
  row_t              in_part;
  cmd_t              in_cmd;
  logic [COL_W-1:0]  in_left_key;
  logic [COL_W-1:0]  in_right_key;
  logic [COL_W-1:0]  last_key;
  logic [COL_W-1:0]  rd_key;
  logic              out_ok;
  logic              accept;
  logic              load_err;
  logic              probe_err;
  logic              emit;
  logic              do_load;
  out_row_t          pk_vals;
  logic [WIDTH_W-1:0] pk_width;

  assign in_row       = in_row_t'(s_tdata[IN_COLS*COL_W-1:0]);
  assign in_part      = in_row[MAX_ARITY-1:0];
  assign in_cmd       = cmd_t'(s_tuser);
  assign in_left_key  = in_part[clamp_col(left_key_pos)];
  assign in_right_key = in_part[clamp_col(right_key_pos)];
  assign last_key     = last_row[clamp_col(left_key_pos)];
  assign rd_key       = rd_row[clamp_col(left_key_pos)];

  assign out_ok    = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE) && out_ok;
  assign accept    = s_tvalid && s_tready;
  assign load_err  = (left_count == CW'(LEFT_DEPTH))
                     || ((left_count != '0) && (in_left_key < last_key));
  assign probe_err = probe_seen && (in_right_key < last_probe_key);
  assign do_load   = accept && (in_cmd == CMD_LOAD) && !load_err;
  assign emit      = (accept && (((in_cmd == CMD_LOAD) && load_err)
                                 || ((in_cmd == CMD_PROBE) && probe_err)))
                     || ((state == S_CHECK) && staged && (rd_key == probe_key) && out_ok)
                     || ((state == S_FINISH) && staged && out_ok);

  assign m_tdata = {{M_PAD_W{1'b0}}, out_width, out_vals};
  assign m_tuser = out_status;

  always_comb begin
    pk_vals  = '0;
    pk_width = '0;
    for (int c = 0; c < MAX_ARITY; c++) begin
      if (left_copy_mask[c]) begin
        pk_vals[pk_width[2:0]] = rd_row[c];
        pk_width = pk_width + 1'b1;
      end
    end
    for (int c = 0; c < MAX_ARITY; c++) begin
      if (right_copy_mask[c]) begin
        pk_vals[pk_width[2:0]] = probe_row[c];
        pk_width = pk_width + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      mem[left_count[AW-1:0]] <= in_part;
    end
    if (state == S_READ) begin
      rd_row <= mem[scan[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_key_pos    <= '0;
      right_key_pos   <= '0;
      left_copy_mask  <= '1;
      right_copy_mask <= '1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_LEFT_KEY_POS:    left_key_pos    <= cfg_data[POS_W-1:0];
        CFG_RIGHT_KEY_POS:   right_key_pos   <= cfg_data[POS_W-1:0];
        CFG_LEFT_COPY_MASK:  left_copy_mask  <= cfg_data[MASK_W-1:0];
        CFG_RIGHT_COPY_MASK: right_copy_mask <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      left_count     <= '0;
      group_start    <= '0;
      scan           <= '0;
      last_probe_key <= '0;
      probe_seen     <= 1'b0;
      staged         <= 1'b0;
      m_tvalid       <= 1'b0;
      m_tlast        <= 1'b0;
      out_status     <= ST_JOINED;
      out_vals       <= '0;
      out_width      <= '0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_cmd)
              CMD_CLEAR: begin
                left_count     <= '0;
                group_start    <= '0;
                last_probe_key <= '0;
                probe_seen     <= 1'b0;
              end
              CMD_LOAD: begin
                if (left_count == CW'(LEFT_DEPTH)) begin
                  m_tlast    <= 1'b1;
                  out_status <= ST_FULL;
                  out_vals   <= '0;
                  out_width  <= '0;
                end else if ((left_count != '0) && (in_left_key < last_key)) begin
                  m_tlast    <= 1'b1;
                  out_status <= ST_LEFT_ORDER;
                  out_vals   <= '0;
                  out_width  <= '0;
                end else begin
                  last_row   <= in_part;
                  left_count <= left_count + 1'b1;
                end
              end
              CMD_PROBE: begin
                if (probe_seen && (in_right_key < last_probe_key)) begin
                  m_tlast    <= 1'b1;
                  out_status <= ST_PROBE_ORDER;
                  out_vals   <= '0;
                  out_width  <= '0;
                end else begin
                  probe_seen     <= 1'b1;
                  last_probe_key <= in_right_key;
                  probe_key      <= in_right_key;
                  probe_row      <= in_part;
                  scan           <= group_start;
                  staged         <= 1'b0;
                  state          <= S_READ;
                end
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          if (scan >= left_count) begin
            state <= S_FINISH;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!staged) begin
            if (rd_key < probe_key) begin
              group_start <= scan + 1'b1;
              scan        <= scan + 1'b1;
              state       <= S_READ;
            end else if (rd_key == probe_key) begin
              staged       <= 1'b1;
              staged_vals  <= pk_vals;
              staged_width <= pk_width;
              scan         <= scan + 1'b1;
              state        <= S_READ;
            end else begin
              state <= S_FINISH;
            end
          end else if (rd_key == probe_key) begin
            if (out_ok) begin
              m_tlast      <= 1'b0;
              out_status   <= ST_JOINED;
              out_vals     <= staged_vals;
              out_width    <= staged_width;
              staged_vals  <= pk_vals;
              staged_width <= pk_width;
              scan         <= scan + 1'b1;
              state        <= S_READ;
            end
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!staged) begin
            state <= S_IDLE;
          end else if (out_ok) begin
            m_tlast    <= 1'b1;
            out_status <= ST_JOINED;
            out_vals   <= staged_vals;
            out_width  <= staged_width;
            staged     <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/sv/tb_sorted_merge_equi_join.sv -----
// Self-checking testbench for the sorted merge equi-join: clear, load and probe requests.
`timescale 1ns / 1ps

module tb_sorted_merge_equi_join;
  import smej_pkg::*;

  localparam int JOIN_DEPTH  = 64;
  localparam int ARITY       = 4;
  localparam int ITEM_TARGET = 410;
  localparam int CALM_AFTER  = 380;
  localparam int SETTLE      = 200;
  localparam int LIMIT       = 2000000;

  typedef struct {
    cmd_t    cmd;
    in_row_t row;
  } request_t;

  typedef struct {
    status_t             status;
    out_row_t            cols;
    logic [WIDTH_W-1:0]  width;
    logic                last;
  } result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata;
  logic [CMD_W-1:0]      s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_DATA_W-1:0]   m_tdata;
  logic [STATUS_W-1:0]   m_tuser;
  logic                  m_tlast;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  request_t request_q[$];
  result_t  result_rows_q[$];
  request_t cur_req;
  logic     req_taken = 1'b0;
  int       send_gap = 0;
  int       recv_gap = 0;
  bit       calm = 1'b0;
  int       item_count = 0;
  int       fail_count = 0;
  int       cycle_count = 0;

  in_row_t      left_store[JOIN_DEPTH];
  int           stored_rows = 0;
  int           scan_start = 0;
  logic [63:0]  last_probe_key = '0;
  bit           probe_seen = 1'b0;
  logic [1:0]   lk_pos = 2'd0;
  logic [1:0]   rk_pos = 2'd0;
  logic [3:0]   l_mask = 4'hF;
  logic [3:0]   r_mask = 4'hF;

  sorted_merge_equi_join #(
    .LEFT_DEPTH(JOIN_DEPTH),
    .MAX_ARITY (ARITY)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast),
    .cfg_we  (cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int key_col(logic [1:0] pos);
    return (int'(pos) >= ARITY) ? ARITY - 1 : int'(pos);
  endfunction

  function automatic void add_result(result_t res);
    result_rows_q.insert(result_rows_q.size(), res);
  endfunction

  function automatic void add_error(status_t st);
    result_t res;
    res.status = st;
    res.cols   = '0;
    res.width  = '0;
    res.last   = 1'b1;
    add_result(res);
  endfunction

  function automatic void apply_request(request_t req);
    logic [63:0] key;
    result_t     res;
    int          n;
    int          w;
    int          r;
    case (req.cmd)
      CMD_CLEAR: begin
        stored_rows    = 0;
        scan_start     = 0;
        last_probe_key = '0;
        probe_seen     = 1'b0;
      end
      CMD_LOAD: begin
        key = req.row[key_col(lk_pos)];
        if (stored_rows >= JOIN_DEPTH) begin
          add_error(ST_FULL);
        end else if (stored_rows > 0 &&
                     key < left_store[stored_rows-1][key_col(lk_pos)]) begin
          add_error(ST_LEFT_ORDER);
        end else begin
          left_store[stored_rows] = req.row;
          stored_rows++;
        end
      end
      CMD_PROBE: begin
        key = req.row[key_col(rk_pos)];
        if (probe_seen && key < last_probe_key) begin
          add_error(ST_PROBE_ORDER);
        end else begin
          probe_seen     = 1'b1;
          last_probe_key = key;
          while (scan_start < stored_rows &&
                 left_store[scan_start][key_col(lk_pos)] < key)
            scan_start++;
          n = 0;
          r = scan_start;
          while (r < stored_rows && left_store[r][key_col(lk_pos)] == key) begin
            res.status = ST_JOINED;
            res.cols   = '0;
            res.last   = 1'b0;
            w = 0;
            for (int c = 0; c < ARITY; c++)
              if (l_mask[c]) begin
                res.cols[w] = left_store[r][c];
                w++;
              end
            for (int c = 0; c < ARITY; c++)
              if (r_mask[c]) begin
                res.cols[w] = req.row[c];
                w++;
              end
            res.width = w[WIDTH_W-1:0];
            add_result(res);
            n++;
            r++;
          end
          if (n > 0)
            result_rows_q[result_rows_q.size()-1].last = 1'b1;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_result();
    result_t            exp;
    out_row_t           got_cols;
    logic [WIDTH_W-1:0] got_width;
    logic [M_PAD_W-1:0] got_pad;
    got_cols  = m_tdata[OUT_COLS*COL_W-1:0];
    got_width = m_tdata[OUT_COLS*COL_W +: WIDTH_W];
    got_pad   = m_tdata[M_DATA_W-1:M_BITS];
    if (result_rows_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, got status %0d width %0d",
               $time, m_tuser, got_width);
      fail_count++;
      return;
    end
    exp = result_rows_q.pop_front();
    if (m_tuser !== exp.status) begin
      $display("%0t: status expected %0d got %0d", $time, exp.status, m_tuser);
      fail_count++;
    end
    if (m_tlast !== exp.last) begin
      $display("%0t: last expected %0d got %0d", $time, exp.last, m_tlast);
      fail_count++;
    end
    if (got_width !== exp.width) begin
      $display("%0t: width expected %0d got %0d", $time, exp.width, got_width);
      fail_count++;
    end
    if (got_pad !== '0) begin
      $display("%0t: pad expected 0 got %h", $time, got_pad);
      fail_count++;
    end
    for (int c = 0; c < OUT_COLS; c++)
      if (got_cols[c] !== exp.cols[c]) begin
        $display("%0t: column %0d expected %h got %h", $time, c, exp.cols[c], got_cols[c]);
        fail_count++;
      end
  endfunction

  function automatic in_row_t make_row(logic [63:0] key, logic [1:0] pos, logic [63:0] fill);
    in_row_t row;
    for (int c = 0; c < IN_COLS; c++) row[c] = fill;
    row[key_col(pos)] = key;
    return row;
  endfunction

  function automatic in_row_t rand_row(logic [63:0] key, logic [1:0] pos);
    in_row_t row;
    for (int c = 0; c < IN_COLS; c++) row[c] = {$urandom, $urandom};
    row[key_col(pos)] = key;
    return row;
  endfunction

  function automatic logic [3:0] rand_mask();
    if ($urandom_range(0, 3) == 0)
      return ($urandom_range(0, 1) == 1) ? 4'hF : 4'h0;
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic push_req(cmd_t cmd, in_row_t row);
    request_t req;
    req.cmd = cmd;
    req.row = row;
    request_q.insert(request_q.size(), req);
    if (cmd != CMD_NONE) item_count++;
  endtask

  task automatic set_config(logic [3:0] lk, logic [3:0] rk, logic [3:0] lm, logic [3:0] rm);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= CFG_LEFT_KEY_POS;
    cfg_data <= lk;
    @(negedge clk);
    cfg_addr <= CFG_RIGHT_KEY_POS;
    cfg_data <= rk;
    @(negedge clk);
    cfg_addr <= CFG_LEFT_COPY_MASK;
    cfg_data <= lm;
    @(negedge clk);
    cfg_addr <= CFG_RIGHT_COPY_MASK;
    cfg_data <= rm;
    @(negedge clk);
    cfg_we   <= 1'b0;
    lk_pos = lk[1:0];
    rk_pos = rk[1:0];
    l_mask = lm;
    r_mask = rm;
  endtask

  task automatic drain();
    while (request_q.size() != 0 || s_tvalid || result_rows_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_phase(int n_loads, int step_max, bit allow_err);
    logic [3:0]  lk;
    logic [3:0]  rk;
    logic [63:0] base;
    logic [63:0] k;
    logic [63:0] pk;
    int          n_probes;
    int          roll;
    lk = 4'($urandom_range(0, 15));
    rk = 4'($urandom_range(0, 15));
    set_config(lk, rk, rand_mask(), rand_mask());
    case ($urandom_range(0, 3))
      0: base = '0;
      1: base = {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FE00;
      2: base = 64'hFFFF_FFFF_FFFF_FE00;
      default: base = 64'($urandom_range(0, 1000));
    endcase
    push_req(CMD_CLEAR, rand_row('0, 2'd0));
    k = base;
    for (int i = 0; i < n_loads; i++) begin
      if (allow_err && i > 0 && $urandom_range(0, 11) == 0) begin
        push_req(CMD_LOAD, rand_row((k == 0) ? k : k - 1, lk[1:0]));
      end else begin
        k = k + 64'($urandom_range(0, step_max));
        push_req(CMD_LOAD, rand_row(k, lk[1:0]));
      end
    end
    pk = base;
    n_probes = n_loads / 2 + $urandom_range(2, 10);
    for (int j = 0; j < n_probes; j++) begin
      roll = $urandom_range(0, 99);
      if (allow_err && roll < 10) begin
        push_req(CMD_PROBE, rand_row((pk == 0) ? pk : pk - 1, rk[1:0]));
      end else if (allow_err && roll < 16) begin
        push_req(CMD_NONE, rand_row({$urandom, $urandom}, 2'd0));
      end else if (allow_err && roll < 22) begin
        k = k + 64'($urandom_range(0, 1));
        push_req(CMD_LOAD, rand_row(k, lk[1:0]));
      end else if (allow_err && roll < 25) begin
        push_req(cmd_t'(CMD_W'($urandom_range(0, 3))), rand_row({$urandom, $urandom}, 2'd0));
      end else begin
        pk = pk + 64'($urandom_range(0, step_max + 1));
        push_req(CMD_PROBE, rand_row(pk, rk[1:0]));
      end
    end
  endtask

  always @(negedge clk) begin
    if (!rst) begin
      if (req_taken) request_q.delete(0);
      if (s_tvalid && !req_taken) begin
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        send_gap <= $urandom_range(0, 17);
        s_tvalid <= 1'b0;
      end else if (request_q.size() > 0) begin
        cur_req  <= request_q[0];
        s_tvalid <= 1'b1;
        s_tdata  <= request_q[0].row;
        s_tuser  <= request_q[0].cmd;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        recv_gap <= $urandom_range(0, 17);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    req_taken <= s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) apply_request(cur_req);
      if (m_tvalid && m_tready) check_result();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int phase;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = CMD_CLEAR;
    m_tready = 1'b0;
    cfg_we   = 1'b0;
    cfg_addr = CFG_LEFT_KEY_POS;
    cfg_data = '0;
    cur_req.cmd = CMD_CLEAR;
    cur_req.row = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_config(4'd0, 4'd0, 4'hF, 4'hF);
    push_req(CMD_CLEAR, make_row('0, 2'd0, '0));
    push_req(CMD_LOAD,  make_row(64'd0, 2'd0, '0));
    push_req(CMD_LOAD,  make_row(64'd5, 2'd0, 64'hA5A5_5A5A_0F0F_F0F0));
    push_req(CMD_LOAD,  make_row(64'd5, 2'd0, 64'h5A5A_A5A5_F0F0_0F0F));
    push_req(CMD_LOAD,  make_row('1, 2'd0, '1));
    push_req(CMD_LOAD,  make_row(64'd3, 2'd0, '1));
    push_req(CMD_NONE,  make_row('1, 2'd0, '1));
    push_req(CMD_PROBE, make_row(64'd0, 2'd0, '1));
    push_req(CMD_PROBE, make_row(64'd5, 2'd0, '0));
    push_req(CMD_PROBE, make_row(64'd5, 2'd0, 64'h0123_4567_89AB_CDEF));
    push_req(CMD_PROBE, make_row(64'd4, 2'd0, '1));
    push_req(CMD_PROBE, make_row(64'd7, 2'd0, '1));
    push_req(CMD_PROBE, make_row('1, 2'd0, '1));
    push_req(CMD_LOAD,  make_row('1, 2'd0, 64'hFEDC_BA98_7654_3210));
    push_req(CMD_PROBE, make_row('1, 2'd0, '0));
    push_req(CMD_CLEAR, make_row('1, 2'd0, '1));
    push_req(CMD_PROBE, make_row(64'd0, 2'd0, '1));
    drain();

    set_config(4'd3, 4'd2, 4'h0, 4'h0);
    push_req(CMD_CLEAR, make_row('0, 2'd0, '0));
    push_req(CMD_LOAD,  make_row(64'd9, 2'd3, '1));
    push_req(CMD_PROBE, make_row(64'd9, 2'd2, '0));
    drain();

    phase = 0;
    while (item_count < ITEM_TARGET) begin
      if (item_count >= CALM_AFTER) calm = 1'b1;
      case (phase)
        1: random_phase(JOIN_DEPTH + 2, 0, 1'b0);
        4: random_phase(JOIN_DEPTH + 2, 1, 1'b0);
        default: random_phase($urandom_range(2, 14), 2, 1'b1);
      endcase
      drain();
      phase++;
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
